FILE: sv/dkp_pkg.sv
// ============================================================================
// dkp_pkg: shared types and constants for the Kronecker product engine
// Parameter defaults, field widths, opcodes, register indexes and the
// command and status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package dkp_pkg;

    // Parameter defaults
    localparam int B_DIM_MAX_DEF  = 8;
    localparam int A_DIM_MAX_DEF  = 256;
    localparam int ELEM_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int IDX_W      = 8;
    localparam int VALUE_W    = 16;
    localparam int POS_W      = 11;
    localparam int PROD_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Request opcodes
    localparam logic OP_B_LOAD = 1'b0;
    localparam logic OP_A_ELEM = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 1'b1;

    typedef struct packed {
        logic accept;   // request taken this cycle
        logic start;    // A element in range: load operands, reset counters
        logic issue;    // read one B element and advance the counters
    } t_dp_cmd;

    typedef struct packed {
        logic a_ok;     // A row and column inside the A range
        logic last;     // counters sit on the final B element
        logic en;       // pipeline may advance
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: sv/dense_kronecker_product.sv
// A B element read passes the store read and stage-one registers, then the
// output register. An A element request holds the input until its last B
// element is read, one store read per cycle (single read port) while the
// output does not stall; a B load or out-of-range A element does not hold it.
// Reset: synchronous, clears control state and sets b_rows = b_cols = 1;
// the B store contents are undefined until written.
// ============================================================================
// dense_kronecker_product: streaming dense Kronecker product C = A (x) B
// Loads the small matrix B into a store and emits one product per B
// element for every in-range A element, B column outer and B row inner.
// ============================================================================
`default_nettype none

module dense_kronecker_product
    import dkp_pkg::*;
#(
    parameter int B_DIM_MAX  = B_DIM_MAX_DEF,
    parameter int A_DIM_MAX  = A_DIM_MAX_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_op,
    input  wire logic        [IDX_W-1:0]      i_row,
    input  wire logic        [IDX_W-1:0]      i_col,
    input  wire logic signed [VALUE_W-1:0]    i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic             [POS_W-1:0]      o_c_row,
    output logic             [POS_W-1:0]      o_c_col,
    output logic signed      [PROD_W-1:0]     o_product,
    output logic                              o_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dkp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    dkp_dp #(
        .B_DIM_MAX  (B_DIM_MAX),
        .A_DIM_MAX  (A_DIM_MAX),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_c_row     (o_c_row),
        .o_c_col     (o_c_col),
        .o_product   (o_product),
        .o_last      (o_last),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

`default_nettype wire

FILE: sv/dkp_ram.sv
// ============================================================================
// dkp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data that holds
// while the read enable is low.
// ============================================================================
`default_nettype none

module dkp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/dkp_ctrl.sv
// ============================================================================
// dkp_ctrl: request controller
// Takes requests while idle and sequences the B element reads of one
// A element, one read per cycle the pipeline can advance.
// ============================================================================
`default_nettype none

module dkp_ctrl
    import dkp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_op,
    output logic         o_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_idle;

    always_comb begin
        w_idle       = (r_state == ST_IDLE);
        o_stall      = !w_idle;
        o_cmd.accept = w_idle && i_valid;
        o_cmd.start  = o_cmd.accept && (i_op == OP_A_ELEM) && i_sts.a_ok;
        o_cmd.issue  = (r_state == ST_RUN) && i_sts.en;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_cmd.issue && i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_RUN))
        else $error("controller did not enter run after start");
`endif

endmodule

`default_nettype wire

FILE: sv/dkp_dp.sv
// ============================================================================
// dkp_dp: Kronecker product datapath
// Configuration registers, B element store, column/row counters, C
// position adders, the multiplier and the output register.
// ============================================================================
`default_nettype none

module dkp_dp
    import dkp_pkg::*;
#(
    parameter int B_DIM_MAX  = B_DIM_MAX_DEF,
    parameter int A_DIM_MAX  = A_DIM_MAX_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                         i_op,
    input  wire logic        [IDX_W-1:0]      i_row,
    input  wire logic        [IDX_W-1:0]      i_col,
    input  wire logic signed [VALUE_W-1:0]    i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic             [POS_W-1:0]      o_c_row,
    output logic             [POS_W-1:0]      o_c_col,
    output logic signed      [PROD_W-1:0]     o_product,
    output logic                              o_last,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_sts                           o_sts
);

    localparam int BW    = (B_DIM_MAX > 1) ? $clog2(B_DIM_MAX) : 1;
    localparam int DEPTH = B_DIM_MAX * B_DIM_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * ELEM_WIDTH;
    localparam int MW    = IDX_W + CFG_DATA_W;
    localparam logic [CFG_DATA_W-1:0] DIM_MAX_C = CFG_DATA_W'(B_DIM_MAX);
    localparam logic [IDX_W-1:0]      B_LIM     = IDX_W'(B_DIM_MAX);
    localparam logic [12:0]           A_LIM     = 13'(A_DIM_MAX);

    // Configuration
    logic [CFG_DATA_W-1:0] r_b_rows;
    logic [CFG_DATA_W-1:0] r_b_cols;
    logic [CFG_DATA_W-1:0] w_nr;
    logic [CFG_DATA_W-1:0] w_nc;

    // Operands and counters
    logic [ELEM_WIDTH-1:0] w_elem;
    logic [ELEM_WIDTH-1:0] r_a;
    logic [POS_W-1:0]      r_row_base;
    logic [POS_W-1:0]      r_col_base;
    logic [MW-1:0]         w_row_prod;
    logic [MW-1:0]         w_col_prod;
    logic [BW-1:0]         r_br;
    logic [BW-1:0]         r_bc;
    logic [BW-1:0]         n_br;
    logic [BW-1:0]         n_bc;
    logic [BW-1:0]         r_br_last;
    logic [BW-1:0]         r_bc_last;
    logic                  w_last;
    logic                  w_en;

    // Store
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [ELEM_WIDTH-1:0] w_rdata;

    // Pipeline
    logic                         r_s1_valid;
    logic signed [ELEM_WIDTH-1:0] r_s1_a;
    logic [POS_W-1:0]             r_s1_row;
    logic [POS_W-1:0]             r_s1_col;
    logic                         r_s1_last;
    logic signed [PW-1:0]         w_prod_full;
    logic signed [PROD_W-1:0]     w_prod;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_rows <= CFG_DATA_W'(1);
            r_b_cols <= CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_B_ROWS: r_b_rows <= i_cfg_data;
                REG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero acts as one, anything above the store size as the store size
    always_comb begin
        priority if (r_b_rows == '0) begin
            w_nr = CFG_DATA_W'(1);
        end else if (r_b_rows > DIM_MAX_C) begin
            w_nr = DIM_MAX_C;
        end else begin
            w_nr = r_b_rows;
        end
        priority if (r_b_cols == '0) begin
            w_nc = CFG_DATA_W'(1);
        end else if (r_b_cols > DIM_MAX_C) begin
            w_nc = DIM_MAX_C;
        end else begin
            w_nc = r_b_cols;
        end
    end

    // ---------------- request decode ----------------
    generate
        if (ELEM_WIDTH <= VALUE_W) begin : g_elem_narrow
            assign w_elem = i_value[ELEM_WIDTH-1:0];
        end else begin : g_elem_wide
            assign w_elem = {{(ELEM_WIDTH-VALUE_W){1'b0}}, i_value};
        end
    endgenerate

    assign o_sts.a_ok = ({5'd0, i_row} < A_LIM) && ({5'd0, i_col} < A_LIM);

    assign w_we    = i_cmd.accept && (i_op == OP_B_LOAD) && (i_row < B_LIM) && (i_col < B_LIM);
    assign w_waddr = AW'(int'(i_row[BW-1:0]) * B_DIM_MAX + int'(i_col[BW-1:0]));

    assign w_row_prod = MW'(i_row) * MW'(w_nr);
    assign w_col_prod = MW'(i_col) * MW'(w_nc);

    // ---------------- counters ----------------
    // Hold the whole pipeline while the output register waits on a stall
    assign w_last     = (r_br == r_br_last) && (r_bc == r_bc_last);
    assign w_en       = !(o_valid && i_stall);
    assign o_sts.last = w_last;
    assign o_sts.en   = w_en;

    always_comb begin
        n_br = r_br;
        n_bc = r_bc;
        priority if (i_cmd.start) begin
            n_br = '0;
            n_bc = '0;
        end else if (i_cmd.issue) begin
            if (w_last) begin
                n_br = '0;
                n_bc = '0;
            end else if (r_br == r_br_last) begin
                n_br = '0;
                n_bc = r_bc + BW'(1);
            end else begin
                n_br = r_br + BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_br      <= '0;
            r_bc      <= '0;
            r_br_last <= '0;
            r_bc_last <= '0;
        end else begin
            r_br <= n_br;
            r_bc <= n_bc;
            if (i_cmd.start) begin
                r_br_last <= BW'(w_nr - CFG_DATA_W'(1));
                r_bc_last <= BW'(w_nc - CFG_DATA_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a        <= w_elem;
            r_row_base <= w_row_prod[POS_W-1:0];
            r_col_base <= w_col_prod[POS_W-1:0];
        end
    end

    // ---------------- B store ----------------
    assign w_raddr = AW'(int'(r_br) * B_DIM_MAX + int'(r_bc));

    dkp_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_b_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_elem),
        .i_re    (i_cmd.issue),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- pipeline ----------------
    assign w_prod_full = $signed(r_s1_a) * $signed(w_rdata);

    generate
        if (PW >= PROD_W) begin : g_prod_trunc
            assign w_prod = w_prod_full[PROD_W-1:0];
        end else begin : g_prod_sext
            assign w_prod = {{(PROD_W-PW){w_prod_full[PW-1]}}, w_prod_full};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_cmd.issue;
            o_valid    <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_a    <= r_a;
            r_s1_row  <= r_row_base + POS_W'(r_br);
            r_s1_col  <= r_col_base + POS_W'(r_bc);
            r_s1_last <= w_last;
        end
        if (w_en && r_s1_valid) begin
            o_product <= w_prod;
            o_c_row   <= r_s1_row;
            o_c_col   <= r_s1_col;
            o_last    <= r_s1_last;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_br <= r_br_last) && (r_bc <= r_bc_last))
        else $error("B counters beyond the size in use");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.issue && w_last) |=> !i_cmd.issue)
        else $error("read issued after the final B element");

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && w_en) |=> (o_valid && o_last))
        else $error("final mark lost on the way to the output");
`endif

endmodule

`default_nettype wire
